FILE: design/arcm_pkg.sv
// Shared types, codes and reset constants of the auto-ranging coordinate mapper.
package arcm_pkg;

    localparam int COORD_BITS_DEF   = 16;
    localparam int OFFSET_BITS      = 15;
    localparam int MODEL_HIGH_RESET = 16383;
    localparam logic [OFFSET_BITS-1:0] MAX_OFFSET_RESET = 15'd320;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_IDX_BITS  = 3;

    typedef enum logic [2:0] {
        OP_SAMPLE       = 3'd0,
        OP_RESET_BOUNDS = 3'd1,
        OP_LOAD_LOW     = 3'd2,
        OP_LOAD_HIGH    = 3'd3,
        OP_FREEZE       = 3'd4,
        OP_UNFREEZE     = 3'd5
    } opcode_t;

    typedef enum logic [REG_IDX_BITS-1:0] {
        REG_MODEL_LOW_X  = 3'd0,
        REG_MODEL_LOW_Y  = 3'd1,
        REG_MODEL_LOW_Z  = 3'd2,
        REG_MODEL_HIGH_X = 3'd3,
        REG_MODEL_HIGH_Y = 3'd4,
        REG_MODEL_HIGH_Z = 3'd5,
        REG_MAX_OFFSET   = 3'd6
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_APPLY,
        ST_DIFF,
        ST_MAG,
        ST_MULT,
        ST_DIV,
        ST_MAP,
        ST_OUT
    } arcm_state_t;

    typedef struct packed {
        logic capture;
        logic apply;
        logic diff;
        logic mag;
        logic mult;
        logic div_step;
        logic div_high;
        logic map;
        logic load_out;
    } arcm_cmd_t;

    typedef struct packed {
        logic is_sample;
    } arcm_stat_t;

endpackage

FILE: design/arcm_regs.sv
// APB-style configuration registers: model box corners and growth limit.
module arcm_regs #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [arcm_pkg::APB_ADDR_BITS-1:0]   paddr,
    input  logic [arcm_pkg::APB_DATA_BITS-1:0]   pwdata,
    output logic [arcm_pkg::APB_DATA_BITS-1:0]   prdata,
    output logic                                 pready,
    output logic signed [COORD_BITS-1:0]         model_low [3],
    output logic signed [COORD_BITS-1:0]         model_high [3],
    output logic [arcm_pkg::OFFSET_BITS-1:0]     max_offset
);
    import arcm_pkg::*;

    logic signed [COORD_BITS-1:0] model_low_reg [3];
    logic signed [COORD_BITS-1:0] model_high_reg [3];
    logic [OFFSET_BITS-1:0]       max_offset_reg;
    logic                         wr_en;
    reg_idx_t                     idx;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite & pready;
    assign idx    = reg_idx_t'(paddr[APB_ADDR_BITS-1:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                model_low_reg[i]  <= '0;
                model_high_reg[i] <= COORD_BITS'(MODEL_HIGH_RESET);
            end
            max_offset_reg <= MAX_OFFSET_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_MODEL_LOW_X:  model_low_reg[0]  <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MODEL_LOW_Y:  model_low_reg[1]  <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MODEL_LOW_Z:  model_low_reg[2]  <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MODEL_HIGH_X: model_high_reg[0] <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MODEL_HIGH_Y: model_high_reg[1] <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MODEL_HIGH_Z: model_high_reg[2] <= $signed(pwdata[COORD_BITS-1:0]);
                REG_MAX_OFFSET:   max_offset_reg    <= pwdata[OFFSET_BITS-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_MODEL_LOW_X:  prdata = APB_DATA_BITS'($unsigned(model_low_reg[0]));
            REG_MODEL_LOW_Y:  prdata = APB_DATA_BITS'($unsigned(model_low_reg[1]));
            REG_MODEL_LOW_Z:  prdata = APB_DATA_BITS'($unsigned(model_low_reg[2]));
            REG_MODEL_HIGH_X: prdata = APB_DATA_BITS'($unsigned(model_high_reg[0]));
            REG_MODEL_HIGH_Y: prdata = APB_DATA_BITS'($unsigned(model_high_reg[1]));
            REG_MODEL_HIGH_Z: prdata = APB_DATA_BITS'($unsigned(model_high_reg[2]));
            REG_MAX_OFFSET:   prdata = APB_DATA_BITS'(max_offset_reg);
            default:          prdata = '0;
        endcase
    end

    assign model_low  = model_low_reg;
    assign model_high = model_high_reg;
    assign max_offset = max_offset_reg;

endmodule

FILE: design/arcm_ctrl.sv
// Sequencing state machine: steps one word through apply, divide, map and output.
module arcm_ctrl #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  arcm_pkg::arcm_stat_t stat,
    output arcm_pkg::arcm_cmd_t  cmd
);
    import arcm_pkg::*;

    localparam int DIV_STEPS = 2 * COORD_BITS;
    localparam int CNT_BITS  = $clog2(DIV_STEPS);
    localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(DIV_STEPS - 1);
    localparam logic [CNT_BITS-1:0] CNT_HIGH = CNT_BITS'(COORD_BITS);

    arcm_state_t         state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_free;

    // The output register may be refilled when empty or when its word leaves now.
    assign out_free = !out_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (item_valid) state_next = ST_APPLY;
            ST_APPLY: state_next = stat.is_sample ? ST_DIFF : ST_OUT;
            ST_DIFF:  state_next = ST_MAG;
            ST_MAG:   state_next = ST_MULT;
            ST_MULT:  state_next = ST_DIV;
            ST_DIV:   if (cnt_reg == CNT_LAST) state_next = ST_MAP;
            ST_MAP:   state_next = ST_OUT;
            ST_OUT:   if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Outputs, divider step count and result valid
    always_comb
    begin
        cmd          = '0;
        item_ready   = 1'b0;
        cnt_next     = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.capture = item_valid;
            end
            ST_APPLY: cmd.apply = 1'b1;
            ST_DIFF:  cmd.diff  = 1'b1;
            ST_MAG:   cmd.mag   = 1'b1;
            ST_MULT:
            begin
                cmd.mult = 1'b1;
                cnt_next = '0;
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cmd.div_high = cnt_reg < CNT_HIGH;
                cnt_next     = cnt_reg + 1'b1;
            end
            ST_MAP:   cmd.map      = 1'b1;
            ST_OUT:   cmd.load_out = out_free;
            default:  ;
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    assign result_valid = out_valid_reg;

endmodule

FILE: design/arcm_axis.sv
// One axis lane: span differences, multiplier, bit-serial divider, clamp and saturation.
module arcm_axis #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                         clk,
    input  arcm_pkg::arcm_cmd_t          cmd,
    input  logic signed [COORD_BITS-1:0] pos,
    input  logic signed [COORD_BITS-1:0] world_low,
    input  logic signed [COORD_BITS-1:0] world_high,
    input  logic signed [COORD_BITS-1:0] out_start,
    input  logic signed [COORD_BITS-1:0] out_end,
    input  logic                         frozen,
    output logic signed [COORD_BITS-1:0] result
);
    import arcm_pkg::*;

    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * COORD_BITS;
    localparam int SW = COORD_BITS + 2;
    localparam logic signed [SW-1:0] SAT_MAX = {3'b000, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [SW-1:0] SAT_MIN = {3'b111, {(COORD_BITS-1){1'b0}}};

    logic signed [DW-1:0]   d_reg, span_reg, dout_reg;
    logic [COORD_BITS-1:0]  d_abs_reg, span_abs_reg, dout_abs_reg;
    logic                   neg_reg, span_zero_reg;
    logic [PW-1:0]          prod_reg;
    logic [COORD_BITS-1:0]  rem_reg, quo_reg;
    logic                   ovf_reg;
    logic signed [COORD_BITS-1:0] res_reg;

    logic [COORD_BITS:0]    trial, trial_sub;
    logic                   fits;
    logic [COORD_BITS:0]    qv;
    logic signed [SW-1:0]   base, qs, sum, lo_m, hi_m, clamped, sat;

    // Restoring division, one quotient bit per cycle. A quotient bit at or above
    // the coordinate width forces the quotient past the coordinate range whatever follows.
    assign trial     = {rem_reg, prod_reg[PW-1]};
    assign fits      = trial >= {1'b0, span_abs_reg};
    assign trial_sub = trial - {1'b0, span_abs_reg};

    always_comb
    begin
        qv   = ovf_reg ? {1'b1, {COORD_BITS{1'b0}}} : {1'b0, quo_reg};
        base = SW'(out_start);
        qs   = $signed({1'b0, qv});
        if (span_zero_reg)
            sum = base;
        else if (neg_reg)
            sum = base - qs;
        else
            sum = base + qs;
        lo_m = (out_start < out_end) ? SW'(out_start) : SW'(out_end);
        hi_m = (out_start < out_end) ? SW'(out_end) : SW'(out_start);
        clamped = sum;
        if (frozen)
        begin
            if (sum < lo_m)
                clamped = lo_m;
            else if (sum > hi_m)
                clamped = hi_m;
        end
        if (clamped > SAT_MAX)
            sat = SAT_MAX;
        else if (clamped < SAT_MIN)
            sat = SAT_MIN;
        else
            sat = clamped;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diff)
        begin
            d_reg    <= DW'(pos) - DW'(world_low);
            span_reg <= DW'(world_high) - DW'(world_low);
            dout_reg <= DW'(out_end) - DW'(out_start);
        end
        if (cmd.mag)
        begin
            d_abs_reg     <= d_reg[DW-1] ? COORD_BITS'(-d_reg) : COORD_BITS'(d_reg);
            span_abs_reg  <= span_reg[DW-1] ? COORD_BITS'(-span_reg) : COORD_BITS'(span_reg);
            dout_abs_reg  <= dout_reg[DW-1] ? COORD_BITS'(-dout_reg) : COORD_BITS'(dout_reg);
            neg_reg       <= d_reg[DW-1] ^ dout_reg[DW-1] ^ span_reg[DW-1];
            span_zero_reg <= (span_reg == '0);
        end
        if (cmd.mult)
        begin
            prod_reg <= PW'(d_abs_reg) * PW'(dout_abs_reg);
            rem_reg  <= '0;
            quo_reg  <= '0;
            ovf_reg  <= 1'b0;
        end
        if (cmd.div_step)
        begin
            prod_reg <= {prod_reg[PW-2:0], 1'b0};
            rem_reg  <= fits ? trial_sub[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
            quo_reg  <= {quo_reg[COORD_BITS-2:0], fits};
            ovf_reg  <= ovf_reg | (fits & cmd.div_high);
        end
        if (cmd.map)
            res_reg <= COORD_BITS'(sat);
    end

    assign result = res_reg;

endmodule

FILE: design/arcm_datapath.sv
// Datapath: word capture, learned world box, three axis lanes and output register.
module arcm_datapath #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  arcm_pkg::arcm_cmd_t              cmd,
    output arcm_pkg::arcm_stat_t             stat,
    input  logic [2:0]                       opcode,
    input  logic signed [COORD_BITS-1:0]     pos_x,
    input  logic signed [COORD_BITS-1:0]     pos_y,
    input  logic signed [COORD_BITS-1:0]     pos_z,
    input  logic signed [COORD_BITS-1:0]     model_low [3],
    input  logic signed [COORD_BITS-1:0]     model_high [3],
    input  logic [arcm_pkg::OFFSET_BITS-1:0] max_offset,
    output logic                             is_point,
    output logic signed [COORD_BITS-1:0]     mapped_x,
    output logic signed [COORD_BITS-1:0]     mapped_y,
    output logic signed [COORD_BITS-1:0]     mapped_z
);
    import arcm_pkg::*;

    localparam int GW = ((COORD_BITS > OFFSET_BITS) ? COORD_BITS : OFFSET_BITS) + 2;

    opcode_t                      op_reg;
    logic signed [COORD_BITS-1:0] pos_reg [3];
    logic signed [COORD_BITS-1:0] wl_reg [3], wl_next [3];
    logic signed [COORD_BITS-1:0] wh_reg [3], wh_next [3];
    logic                         frozen_reg, frozen_next;
    logic                         is_point_reg;
    logic signed [COORD_BITS-1:0] mapped_reg [3];

    logic signed [GW-1:0]         mo_g;
    logic signed [GW-1:0]         lo_gap [3], hi_gap [3];
    logic signed [COORD_BITS-1:0] grown_low [3], grown_high [3];
    logic                         below, above;
    logic signed [COORD_BITS-1:0] lane_res [3];

    assign stat.is_sample = (op_reg == OP_SAMPLE);

    // Growth toward the sample, limited to max_offset per axis.
    always_comb
    begin
        mo_g  = $signed(GW'(max_offset));
        below = 1'b0;
        above = 1'b0;
        for (int a = 0; a < 3; a++)
        begin
            lo_gap[a] = GW'(pos_reg[a]) - GW'(wl_reg[a]);
            hi_gap[a] = GW'(pos_reg[a]) - GW'(wh_reg[a]);
            below     = below | (pos_reg[a] < wl_reg[a]);
            above     = above | (pos_reg[a] > wh_reg[a]);
            if (lo_gap[a] < -mo_g)
                grown_low[a] = COORD_BITS'(GW'(wl_reg[a]) - mo_g);
            else if (lo_gap[a] < 0)
                grown_low[a] = pos_reg[a];
            else
                grown_low[a] = wl_reg[a];
            if (hi_gap[a] > mo_g)
                grown_high[a] = COORD_BITS'(GW'(wh_reg[a]) + mo_g);
            else if (hi_gap[a] > 0)
                grown_high[a] = pos_reg[a];
            else
                grown_high[a] = wh_reg[a];
        end
    end

    always_comb
    begin
        wl_next     = wl_reg;
        wh_next     = wh_reg;
        frozen_next = frozen_reg;
        if (cmd.apply)
        begin
            unique case (op_reg)
                OP_SAMPLE:
                begin
                    // The lower corner wins when the sample lies outside both.
                    if (!frozen_reg && below)
                        wl_next = grown_low;
                    else if (!frozen_reg && above)
                        wh_next = grown_high;
                end
                OP_RESET_BOUNDS:
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        wl_next[a] = '0;
                        wh_next[a] = '0;
                    end
                    frozen_next = 1'b0;
                end
                OP_LOAD_LOW:  wl_next = pos_reg;
                OP_LOAD_HIGH:
                begin
                    wh_next     = pos_reg;
                    frozen_next = 1'b1;
                end
                OP_FREEZE:    frozen_next = 1'b1;
                OP_UNFREEZE:  frozen_next = 1'b0;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                wl_reg[a] <= '0;
                wh_reg[a] <= '0;
            end
            frozen_reg <= 1'b0;
        end
        else
        begin
            wl_reg     <= wl_next;
            wh_reg     <= wh_next;
            frozen_reg <= frozen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg     <= opcode_t'(opcode);
            pos_reg[0] <= pos_x;
            pos_reg[1] <= pos_y;
            pos_reg[2] <= pos_z;
        end
        if (cmd.load_out)
        begin
            is_point_reg <= stat.is_sample;
            for (int a = 0; a < 3; a++)
                mapped_reg[a] <= stat.is_sample ? lane_res[a] : '0;
        end
    end

    // X maps low to low; Y and Z are inverted, so the world lower bound
    // lands on the model far corner.
    for (genvar a = 0; a < 3; a++)
    begin : g_lane
        logic signed [COORD_BITS-1:0] o_start, o_end;
        if (a == 0)
        begin : g_direct
            assign o_start = model_low[a];
            assign o_end   = model_high[a];
        end
        else
        begin : g_inverted
            assign o_start = model_high[a];
            assign o_end   = model_low[a];
        end

        arcm_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos_reg[a]),
            .world_low  (wl_reg[a]),
            .world_high (wh_reg[a]),
            .out_start  (o_start),
            .out_end    (o_end),
            .frozen     (frozen_reg),
            .result     (lane_res[a])
        );
    end

    assign is_point = is_point_reg;
    assign mapped_x = mapped_reg[0];
    assign mapped_y = mapped_reg[1];
    assign mapped_z = mapped_reg[2];

endmodule

FILE: design/auto_ranging_coordinate_mapper_core.sv
// Top level of the auto-ranging coordinate mapper: registers, controller and datapath.
//
// The block takes one word at a time on the item channel (opcode and a signed
// 3-axis position) and answers each with exactly one word on the result channel.
// Opcode SAMPLE grows the learned world box toward the position unless frozen,
// then maps each axis linearly onto the model box (Y and Z inverted), clamping
// to the model box when frozen and saturating to the coordinate range. The other
// opcodes reset, load, freeze or unfreeze the world box or, if spare, leave it alone,
// and answer with is_point low and zero coordinates.
// A sample word steps through apply, difference, magnitude, multiply, the divider
// steps, map and output; control words go from apply straight to output. A new word
// can be taken in the cycle after the result is loaded. The bit-serial restoring
// divider gives one quotient bit per cycle in each of the three lanes, side by side.
// The result sits in an output register. If the receiver stalls, the block still
// accepts the next word and works on it, and holds at its final step until the
// output register is free. Reset clears the world box, the frozen flag and the
// result valid, and loads the configuration registers with their defaults.
// The user writes configuration over the APB-style port only while no word is in
// work; the block itself does not enforce it.
module auto_ranging_coordinate_mapper_core #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [arcm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [arcm_pkg::APB_DATA_BITS-1:0] pwdata,
    output logic [arcm_pkg::APB_DATA_BITS-1:0] prdata,
    output logic                               pready,
    input  logic                               item_valid,
    output logic                               item_ready,
    input  logic [2:0]                         opcode,
    input  logic signed [COORD_BITS-1:0]       pos_x,
    input  logic signed [COORD_BITS-1:0]       pos_y,
    input  logic signed [COORD_BITS-1:0]       pos_z,
    output logic                               result_valid,
    input  logic                               result_ready,
    output logic                               is_point,
    output logic signed [COORD_BITS-1:0]       mapped_x,
    output logic signed [COORD_BITS-1:0]       mapped_y,
    output logic signed [COORD_BITS-1:0]       mapped_z
);
    import arcm_pkg::*;

    logic signed [COORD_BITS-1:0] model_low [3];
    logic signed [COORD_BITS-1:0] model_high [3];
    logic [OFFSET_BITS-1:0]       max_offset;
    arcm_cmd_t                    cmd;
    arcm_stat_t                   stat;

    // Configuration registers; the user keeps the model corners and the growth limit
    // static while words are in work, which the block itself does not enforce.
    arcm_regs #(
        .COORD_BITS (COORD_BITS)
    ) u_regs (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .model_low  (model_low),
        .model_high (model_high),
        .max_offset (max_offset)
    );

    // The controller owns both handshakes and the divider step count.
    arcm_ctrl #(
        .COORD_BITS (COORD_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .stat         (stat),
        .cmd          (cmd)
    );

    // The datapath holds the world box, the three axis lanes and the result word.
    arcm_datapath #(
        .COORD_BITS (COORD_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .opcode     (opcode),
        .pos_x      (pos_x),
        .pos_y      (pos_y),
        .pos_z      (pos_z),
        .model_low  (model_low),
        .model_high (model_high),
        .max_offset (max_offset),
        .is_point   (is_point),
        .mapped_x   (mapped_x),
        .mapped_y   (mapped_y),
        .mapped_z   (mapped_z)
    );

endmodule

FILE: design/arcm_checker.sv
// Port-level checks on the coordinate mapper, bound to its top level.
module arcm_checker #(
    parameter int COORD_BITS = arcm_pkg::COORD_BITS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         item_valid,
    input logic                         item_ready,
    input logic                         result_valid,
    input logic                         result_ready,
    input logic                         is_point,
    input logic signed [COORD_BITS-1:0] mapped_x,
    input logic signed [COORD_BITS-1:0] mapped_y,
    input logic signed [COORD_BITS-1:0] mapped_z
);

    // One word at a time: the block is busy straight after taking a word.
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready
    ) else $error("item_ready high in the cycle after a word was taken");

    // Control words answer with zero coordinates.
    a_control_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !is_point |-> mapped_x == '0 && mapped_y == '0 && mapped_z == '0
    ) else $error("control word answered with nonzero coordinates");

    // A fresh result only appears at the end of work on a word.
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> $past(!item_ready)
    ) else $error("result appeared while the block was idle");

    // A stalled result holds.
    a_result_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(is_point)
            && $stable(mapped_x) && $stable(mapped_y) && $stable(mapped_z)
    ) else $error("stalled result changed or dropped");

endmodule

bind auto_ranging_coordinate_mapper_core arcm_checker #(
    .COORD_BITS (COORD_BITS)
) u_arcm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .is_point     (is_point),
    .mapped_x     (mapped_x),
    .mapped_y     (mapped_y),
    .mapped_z     (mapped_z)
);

FILE: dv/arcm_result_checker.sv
// Checker for the coordinate mapper: tracks the register file, predicts each word and compares.
`timescale 1ns / 100ps

module arcm_result_checker #(
    parameter int CB = arcm_pkg::COORD_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic                               pready,
    input  logic [arcm_pkg::APB_ADDR_BITS-1:0] paddr,
    input  logic [arcm_pkg::APB_DATA_BITS-1:0] pwdata,
    input  logic                               item_valid,
    input  logic                               item_ready,
    input  logic [2:0]                         opcode,
    input  logic signed [CB-1:0]               pos_x,
    input  logic signed [CB-1:0]               pos_y,
    input  logic signed [CB-1:0]               pos_z,
    input  logic                               result_valid,
    input  logic                               result_ready,
    input  logic                               is_point,
    input  logic signed [CB-1:0]               mapped_x,
    input  logic signed [CB-1:0]               mapped_y,
    input  logic signed [CB-1:0]               mapped_z,
    output int                                 awaited,
    output int                                 failures,
    output int                                 results_seen,
    output int                                 points_seen
);
    import arcm_pkg::*;

    typedef struct packed {
        logic                 is_point;
        logic signed [CB-1:0] x;
        logic signed [CB-1:0] y;
        logic signed [CB-1:0] z;
    } map_result_t;

    // Register file as the block should hold it.
    logic signed [CB-1:0]   model_near [3];
    logic signed [CB-1:0]   model_far  [3];
    logic [OFFSET_BITS-1:0] growth_limit;

    // Learned world box and frozen flag.
    logic signed [CB-1:0] box_low  [3];
    logic signed [CB-1:0] box_high [3];
    logic                 box_frozen;

    map_result_t awaited_results [$];
    int          mismatch_count;
    int          result_count;
    int          point_count;

    function automatic void write_register(logic [APB_ADDR_BITS-1:0] addr,
                                           logic [APB_DATA_BITS-1:0] data);
        reg_idx_t idx;
        idx = reg_idx_t'(addr[APB_ADDR_BITS-1:2]);
        case (idx)
            REG_MODEL_LOW_X:  model_near[0] = data[CB-1:0];
            REG_MODEL_LOW_Y:  model_near[1] = data[CB-1:0];
            REG_MODEL_LOW_Z:  model_near[2] = data[CB-1:0];
            REG_MODEL_HIGH_X: model_far[0]  = data[CB-1:0];
            REG_MODEL_HIGH_Y: model_far[1]  = data[CB-1:0];
            REG_MODEL_HIGH_Z: model_far[2]  = data[CB-1:0];
            REG_MAX_OFFSET:   growth_limit  = data[OFFSET_BITS-1:0];
            default:          ;
        endcase
    endfunction

    // Linear map of one axis from the world span onto o0..o1, truncating toward zero.
    function automatic logic signed [CB-1:0] scale_axis(longint v, longint lo, longint hi,
                                                        longint o0, longint o1);
        longint span;
        longint rel;
        longint dout;
        longint res;
        longint lim;
        span = hi - lo;
        rel  = v - lo;
        dout = o1 - o0;
        lim  = (longint'(1) <<< (CB - 1)) - 1;
        if (span == 0)
            res = o0;
        else
            res = o0 + (rel * dout) / span;
        if (box_frozen)
        begin
            if (res < ((o0 < o1) ? o0 : o1)) res = (o0 < o1) ? o0 : o1;
            if (res > ((o0 < o1) ? o1 : o0)) res = (o0 < o1) ? o1 : o0;
        end
        if (res > lim)
            res = lim;
        if (res < -lim - 1)
            res = -lim - 1;
        return res[CB-1:0];
    endfunction

    function automatic map_result_t step_mapper(logic [2:0] op, logic signed [CB-1:0] px,
                                                logic signed [CB-1:0] py,
                                                logic signed [CB-1:0] pz);
        map_result_t          res;
        logic signed [CB-1:0] pos [3];
        longint               delta;
        logic                 below;
        logic                 above;
        pos[0] = px;
        pos[1] = py;
        pos[2] = pz;
        res    = '0;
        below  = 1'b0;
        above  = 1'b0;
        case (op)
            OP_SAMPLE:
            begin
                if (!box_frozen)
                begin
                    for (int i = 0; i < 3; i++)
                    begin
                        if (pos[i] < box_low[i])  below = 1'b1;
                        if (pos[i] > box_high[i]) above = 1'b1;
                    end
                    // The lower corner wins when the sample is outside both.
                    for (int i = 0; i < 3; i++)
                    begin
                        if (below)
                        begin
                            delta = longint'(pos[i]) - longint'(box_low[i]);
                            if (delta < -longint'(growth_limit))
                                delta = -longint'(growth_limit);
                            if (delta > 0) delta = 0;
                            box_low[i] = CB'(longint'(box_low[i]) + delta);
                        end
                        else if (above)
                        begin
                            delta = longint'(pos[i]) - longint'(box_high[i]);
                            if (delta > longint'(growth_limit))
                                delta = longint'(growth_limit);
                            if (delta < 0) delta = 0;
                            box_high[i] = CB'(longint'(box_high[i]) + delta);
                        end
                    end
                end
                res.is_point = 1'b1;
                res.x = scale_axis(longint'(pos[0]), longint'(box_low[0]),
                                   longint'(box_high[0]), longint'(model_near[0]),
                                   longint'(model_far[0]));
                res.y = scale_axis(longint'(pos[1]), longint'(box_low[1]),
                                   longint'(box_high[1]), longint'(model_far[1]),
                                   longint'(model_near[1]));
                res.z = scale_axis(longint'(pos[2]), longint'(box_low[2]),
                                   longint'(box_high[2]), longint'(model_far[2]),
                                   longint'(model_near[2]));
            end
            OP_RESET_BOUNDS:
            begin
                for (int i = 0; i < 3; i++)
                begin
                    box_low[i]  = '0;
                    box_high[i] = '0;
                end
                box_frozen = 1'b0;
            end
            OP_LOAD_LOW:
            begin
                for (int i = 0; i < 3; i++)
                    box_low[i] = pos[i];
            end
            OP_LOAD_HIGH:
            begin
                for (int i = 0; i < 3; i++)
                    box_high[i] = pos[i];
                box_frozen = 1'b1;
            end
            OP_FREEZE:   box_frozen = 1'b1;
            OP_UNFREEZE: box_frozen = 1'b0;
            default:     ;
        endcase
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        map_result_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < 3; i++)
            begin
                model_near[i] = '0;
                model_far[i]  = CB'(MODEL_HIGH_RESET);
                box_low[i]    = '0;
                box_high[i]   = '0;
            end
            growth_limit = MAX_OFFSET_RESET;
            box_frozen   = 1'b0;
            awaited_results.delete();
            mismatch_count = 0;
            result_count   = 0;
            point_count    = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
                write_register(paddr, pwdata);
            // A result never belongs to a word taken at the same edge, so compare first.
            if (result_valid && result_ready)
            begin
                result_count++;
                if (is_point)
                    point_count++;
                if (awaited_results.size() == 0)
                begin
                    $error("result word with none awaited: is_point %0d, x %0d, y %0d, z %0d",
                           is_point, mapped_x, mapped_y, mapped_z);
                    mismatch_count++;
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (want.is_point !== is_point)
                    begin
                        $error("is_point: expected %0d, got %0d", want.is_point, is_point);
                        mismatch_count++;
                    end
                    if (want.x !== mapped_x)
                    begin
                        $error("mapped_x: expected %0d, got %0d", want.x, mapped_x);
                        mismatch_count++;
                    end
                    if (want.y !== mapped_y)
                    begin
                        $error("mapped_y: expected %0d, got %0d", want.y, mapped_y);
                        mismatch_count++;
                    end
                    if (want.z !== mapped_z)
                    begin
                        $error("mapped_z: expected %0d, got %0d", want.z, mapped_z);
                        mismatch_count++;
                    end
                end
            end
            if (item_valid && item_ready)
                awaited_results.push_back(step_mapper(opcode, pos_x, pos_y, pos_z));
        end
        awaited      <= awaited_results.size();
        failures     <= mismatch_count;
        results_seen <= result_count;
        points_seen  <= point_count;
    end

endmodule

FILE: dv/auto_ranging_coordinate_mapper_core_tb.sv
// Testbench top of the coordinate mapper: clock, reset, stimulus, register writes and verdict.
`timescale 1ns / 100ps

module auto_ranging_coordinate_mapper_core_tb;
    import arcm_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    // Spare opcodes: the block must leave its state alone and answer with a control word.
    localparam logic [2:0] OP_SPARE_A = 3'd6;
    localparam logic [2:0] OP_SPARE_B = 3'd7;

    localparam logic signed [CB-1:0] C_MAX = {1'b0, {(CB-1){1'b1}}};
    localparam logic signed [CB-1:0] C_MIN = {1'b1, {(CB-1){1'b0}}};

    // Six random blocks of 250 words: two per stall regime.
    localparam int BLOCKS      = 6;
    localparam int BLOCK_WORDS = 250;
    // Allow a margin after the last result, longer than a sample occupies the block.
    localparam int TAIL_CYCLES = 2 * CB + 16;
    // Watchdog limit, well above the slowest legal run.
    localparam int CYCLE_LIMIT = 1000000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    logic                     item_valid;
    logic                     item_ready;
    logic [2:0]               opcode;
    logic signed [CB-1:0]     pos_x;
    logic signed [CB-1:0]     pos_y;
    logic signed [CB-1:0]     pos_z;
    logic                     result_valid;
    logic                     result_ready;
    logic                     is_point;
    logic signed [CB-1:0]     mapped_x;
    logic signed [CB-1:0]     mapped_y;
    logic signed [CB-1:0]     mapped_z;

    int awaited;
    int failures;
    int results_seen;
    int points_seen;

    // Stall rates in percent. The receiver rate is read by another process, so it
    // changes only through nonblocking updates.
    int send_idle_pct;
    int recv_idle_pct;
    int words_sent;
    int settings_used;
    int cycle_count;

    always #2 clk = ~clk;

    auto_ranging_coordinate_mapper_core #(
        .COORD_BITS(CB)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_point     (is_point),
        .mapped_x     (mapped_x),
        .mapped_y     (mapped_y),
        .mapped_z     (mapped_z)
    );

    arcm_result_checker #(
        .CB(CB)
    ) i_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .opcode       (opcode),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .is_point     (is_point),
        .mapped_x     (mapped_x),
        .mapped_y     (mapped_y),
        .mapped_z     (mapped_z),
        .awaited      (awaited),
        .failures     (failures),
        .results_seen (results_seen),
        .points_seen  (points_seen)
    );

    // The receiver decides afresh at every edge whether it will take a result word.
    always @(posedge clk)
        result_ready <= ($urandom_range(99) >= recv_idle_pct);

    // Watchdog: a hung handshake ends the run here.
    initial
    begin : watchdog
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("CHECKS FAILED");
        $finish;
    end

    // One register write: a setup phase, then an access phase in which the write lands.
    // The final idle phase keeps back-to-back writes from touching psel twice in one step.
    task automatic write_reg(reg_idx_t idx, logic signed [APB_DATA_BITS-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic program_setting(logic signed [CB-1:0] lx, logic signed [CB-1:0] ly,
                                   logic signed [CB-1:0] lz, logic signed [CB-1:0] hx,
                                   logic signed [CB-1:0] hy, logic signed [CB-1:0] hz,
                                   logic [OFFSET_BITS-1:0] offset);
        write_reg(REG_MODEL_LOW_X, APB_DATA_BITS'(lx));
        write_reg(REG_MODEL_LOW_Y, APB_DATA_BITS'(ly));
        write_reg(REG_MODEL_LOW_Z, APB_DATA_BITS'(lz));
        write_reg(REG_MODEL_HIGH_X, APB_DATA_BITS'(hx));
        write_reg(REG_MODEL_HIGH_Y, APB_DATA_BITS'(hy));
        write_reg(REG_MODEL_HIGH_Z, APB_DATA_BITS'(hz));
        write_reg(REG_MAX_OFFSET, APB_DATA_BITS'(offset));
        settings_used++;
    endtask

    // Offer one word, idling first at the current sender rate, and hold it until taken.
    task automatic send_word(logic [2:0] op, logic signed [CB-1:0] x,
                             logic signed [CB-1:0] y, logic signed [CB-1:0] z);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        opcode     <= op;
        pos_x      <= x;
        pos_y      <= y;
        pos_z      <= z;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        words_sent++;
    endtask

    // Withdraw valid and wait until every awaited result word has been taken.
    task automatic drain_results();
        item_valid <= 1'b0;
        @(posedge clk);
        while (awaited != 0)
            @(posedge clk);
    endtask

    // Coordinates lean towards a small working volume so that the box grows and
    // the samples land inside it, with extremes and fully random values mixed in.
    function automatic logic signed [CB-1:0] pick_coord();
        logic signed [CB-1:0] v;
        case ($urandom_range(9))
            0:       v = C_MAX;
            1:       v = C_MIN;
            2:       v = CB'(-1);
            3, 4, 5: v = CB'($urandom);
            default: v = CB'(int'($urandom_range(4000)) - 2000);
        endcase
        return v;
    endfunction

    // Mostly samples; corner loads and freezes are frequent enough to keep the box moving.
    function automatic logic [2:0] pick_opcode();
        int r;
        r = $urandom_range(99);
        if (r < 68)      return OP_SAMPLE;
        else if (r < 73) return OP_RESET_BOUNDS;
        else if (r < 78) return OP_LOAD_LOW;
        else if (r < 83) return OP_LOAD_HIGH;
        else if (r < 88) return OP_FREEZE;
        else if (r < 95) return OP_UNFREEZE;
        else if (r < 97) return OP_SPARE_A;
        else             return OP_SPARE_B;
    endfunction

    initial
    begin : stimulus
        logic [OFFSET_BITS-1:0] offset;
        rst_n        <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        item_valid   <= 1'b0;
        opcode       <= OP_SAMPLE;
        pos_x        <= '0;
        pos_y        <= '0;
        pos_z        <= '0;
        result_ready <= 1'b0;
        send_idle_pct = 13;
        recv_idle_pct <= 58;
        words_sent    = 0;
        settings_used = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words under the reset register values. The world box starts as a
        // single point, so the first sample exercises the degenerate range.
        send_word(OP_SAMPLE, 0, 0, 0);
        // Growth towards the upper corner, limited per axis, with saturated outputs.
        send_word(OP_SAMPLE, C_MAX, C_MAX, C_MAX);
        send_word(OP_SAMPLE, C_MIN, C_MIN, C_MIN);
        // Outside on both sides at once: only the lower corner may move.
        send_word(OP_SAMPLE, C_MIN, C_MAX, 0);
        send_word(OP_SAMPLE, 100, -5, 200);
        // While frozen the box stays put and results are clamped to the model box.
        send_word(OP_FREEZE, C_MAX, C_MIN, 1);
        send_word(OP_SAMPLE, C_MAX, C_MIN, 0);
        send_word(OP_UNFREEZE, -1, -1, -1);
        send_word(OP_SAMPLE, 50, 50, 50);
        // Loading the lower corner must not touch the frozen flag.
        send_word(OP_LOAD_LOW, C_MIN, C_MIN, C_MIN);
        send_word(OP_SAMPLE, C_MIN, 0, 1);
        drain_results();
        send_word(OP_LOAD_HIGH, C_MAX, C_MAX, C_MAX);
        send_word(OP_SAMPLE, C_MAX, C_MIN, 0);
        send_word(OP_SAMPLE, 0, -1, 1);
        // A reversed box maps with a negative span.
        send_word(OP_LOAD_LOW, 1000, 1000, 1000);
        send_word(OP_LOAD_HIGH, -1000, -1000, -1000);
        send_word(OP_SAMPLE, 0, 500, -2000);
        // Degenerate box while frozen.
        send_word(OP_LOAD_LOW, 5, 5, 5);
        send_word(OP_LOAD_HIGH, 5, 5, 5);
        send_word(OP_SAMPLE, 7, -7, 5);
        send_word(OP_SPARE_A, C_MAX, C_MIN, -1);
        send_word(OP_SPARE_B, -1, 0, C_MAX);
        send_word(OP_RESET_BOUNDS, 123, -456, 789);
        send_word(OP_SAMPLE, 1, -1, 0);
        drain_results();

        for (int blk = 0; blk < BLOCKS; blk++)
        begin
            // Sender idles lightly and the receiver heavily, then the reverse, then
            // neither; the block is quiet here, so the registers may be rewritten.
            case (blk / 2)
                0:
                begin
                    send_idle_pct = 13;
                    recv_idle_pct <= 58;
                end
                1:
                begin
                    send_idle_pct = 58;
                    recv_idle_pct <= 13;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct <= 0;
                end
            endcase
            if (blk == 0)
            begin
                // Widest model box and the largest growth limit.
                program_setting(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, '1);
            end
            else if (blk == 1)
            begin
                // Reversed X and Z, flat Y, and no growth at all.
                program_setting(C_MAX, 0, 16383, C_MIN, 0, -16384, '0);
            end
            else
            begin
                if ($urandom_range(3) == 0)
                    offset = OFFSET_BITS'($urandom_range(32767));
                else
                    offset = OFFSET_BITS'($urandom_range(1, 600));
                program_setting(pick_coord(), pick_coord(), pick_coord(),
                                pick_coord(), pick_coord(), pick_coord(), offset);
            end
            for (int n = 0; n < BLOCK_WORDS; n++)
            begin
                // Now and then the sender holds off until the block has fully drained.
                if ($urandom_range(199) == 0)
                    drain_results();
                send_word(pick_opcode(), pick_coord(), pick_coord(), pick_coord());
            end
            drain_results();
        end

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Run covered %0d words under %0d register settings: %0d results compared,",
                 words_sent, settings_used, results_seen);
        $display("%0d of them mapped samples, across three sender and receiver stall regimes.",
                 points_seen);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
